FILE: sv/erts_pkg.sv
// ----------------------------------------------------------------------------
// erts_pkg
// Shared types and constants for the echo reply tracker with RTT statistics.
// ----------------------------------------------------------------------------
package erts_pkg;

	localparam int unsigned SEQ_W      = 32;
	localparam int unsigned TIME_W     = 48;
	localparam int unsigned RTT_W      = 32;
	localparam int unsigned FRAC_BITS  = 8;
	localparam int unsigned MEAN_W     = RTT_W + FRAC_BITS;
	localparam int unsigned DIV_CNT_W  = $clog2(MEAN_W);
	localparam int unsigned HALF_W     = MEAN_W / 2;
	localparam int unsigned PROD_W     = 2 * MEAN_W;
	localparam int unsigned VAR_W      = 64;
	localparam int unsigned VAR_SHIFT  = 2 * FRAC_BITS;

	localparam logic       CMD_SEND   = 1'b0;
	localparam logic       CMD_REPLY  = 1'b1;
	localparam logic [7:0] REPLY_TYPE = 8'd129;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] now_ns;
		logic [7:0]        msg_type;
		logic [31:0]       reply_ident;
		logic [SEQ_W-1:0]  reply_seq;
		logic [TIME_W-1:0] sent_ns;
	} req_item_t;

	typedef struct packed {
		logic              kind;
		logic [SEQ_W-1:0]  seq_out;
		logic              is_dup;
		logic [RTT_W-1:0]  rtt_ns;
		logic [31:0]       sent_count;
		logic [31:0]       recv_count;
		logic [31:0]       dup_count;
		logic [MEAN_W-1:0] mean_rtt;
		logic [RTT_W-1:0]  min_rtt;
		logic [RTT_W-1:0]  max_rtt;
		logic [VAR_W-1:0]  var_sum;
	} rsp_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic             outstanding;
	} tbl_entry_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} tbl_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SLOT,
		ST_EVAL,
		ST_STATS,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		SP_IDLE,
		SP_DIV,
		SP_MEAN,
		SP_ABS,
		SP_MUL,
		SP_ADD,
		SP_VAR
	} stats_state_t;

endpackage

FILE: sv/echo_reply_tracker_rtt_stats.sv
// ----------------------------------------------------------------------------
// echo_reply_tracker_rtt_stats
// Echo request/reply tracker with sequence table and running RTT statistics.
// ----------------------------------------------------------------------------
// Send items get the next sequence number (first is 1) and mark it
// outstanding in a table slot, sequence mod TABLE_DEPTH; replies with type
// 129 and the configured identifier are matched against that slot, flagged
// as duplicates when already answered, and otherwise fold their RTT into a
// fixed-point mean (8 fraction bits), a saturating variance sum, min and max.
// Other replies are taken and give no result. After reset the table is
// cleared, and no item is taken while that runs.
// One item is in work at a time: each waits on the slot remainder, and a
// counted reply also on the 40-step bit-serial mean divider. The result
// register frees the input side, so the next item is taken while a result
// waits on rsp_stall.
module echo_reply_tracker_rtt_stats import erts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_item_t   req_item,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_item_t   rsp_item,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	ctl_state_t       state_q;
	ctl_state_t       state_d;
	logic [31:0]      echo_ident_q;
	logic [31:0]      sent_ctr_q;
	logic [31:0]      recv_ctr_q;
	logic [31:0]      dup_ctr_q;
	logic             cmd_q;
	logic [SEQ_W-1:0] seq_q;
	logic [RTT_W-1:0] rtt_q;
	logic             dup_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic             accept;
	logic             reply_ok;
	logic             take;
	logic [TIME_W:0]  rtt_diff;
	logic [RTT_W-1:0] rtt_new;
	logic             hit;
	logic             dup_now;
	logic             rsp_load;
	logic             rem_start;
	logic             rem_done;
	logic [AW-1:0]    rem_slot;
	tbl_cmd_t         tbl_cmd;
	tbl_entry_t       tbl_wdata;
	tbl_entry_t       tbl_rdata;
	logic             tbl_clearing;
	logic             stats_start;
	logic             stats_done;
	logic [MEAN_W-1:0] st_mean;
	logic [RTT_W-1:0] st_min;
	logic [RTT_W-1:0] st_max;
	logic [VAR_W-1:0] st_var;

	assign accept   = req_valid && !req_stall;
	assign reply_ok = (req_item.msg_type == REPLY_TYPE) &&
	                  (req_item.reply_ident == echo_ident_q);
	assign take     = accept && ((req_item.cmd == CMD_SEND) || reply_ok);

	// saturate to 0 .. 2^32-1
	assign rtt_diff = {1'b0, req_item.now_ns} - {1'b0, req_item.sent_ns};
	always_comb begin
		priority if (rtt_diff[TIME_W]) begin
			rtt_new = '0;
		end else if (|rtt_diff[TIME_W-1:RTT_W]) begin
			rtt_new = '1;
		end else begin
			rtt_new = rtt_diff[RTT_W-1:0];
		end
	end

	assign hit     = (tbl_rdata.seq == seq_q);
	assign dup_now = hit && !tbl_rdata.outstanding;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (!tbl_clearing) state_d = ST_IDLE;
			ST_IDLE:  if (take) state_d = ST_SLOT;
			ST_SLOT:  if (rem_done) state_d = (cmd_q == CMD_SEND) ? ST_DONE : ST_EVAL;
			ST_EVAL:  state_d = dup_now ? ST_DONE : ST_STATS;
			ST_STATS: if (stats_done) state_d = ST_DONE;
			ST_DONE:  if (rsp_load) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		req_stall   = (state_q != ST_IDLE);
		rem_start   = take;
		tbl_cmd     = '0;
		tbl_wdata   = '0;
		stats_start = 1'b0;
		rsp_load    = 1'b0;
		unique case (state_q)
			ST_SLOT: begin
				if (rem_done) begin
					if (cmd_q == CMD_SEND) begin
						tbl_cmd.wr            = 1'b1;
						tbl_wdata.seq         = seq_q;
						tbl_wdata.outstanding = 1'b1;
					end else begin
						tbl_cmd.rd = 1'b1;
					end
				end
			end
			ST_EVAL: begin
				// answered now: retire the entry
				if (hit && tbl_rdata.outstanding) begin
					tbl_cmd.wr            = 1'b1;
					tbl_wdata.seq         = seq_q;
					tbl_wdata.outstanding = 1'b0;
				end
				stats_start = !dup_now;
			end
			ST_DONE: begin
				rsp_load = !rsp_valid_q || !rsp_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			echo_ident_q <= '0;
			sent_ctr_q   <= '0;
			recv_ctr_q   <= '0;
			dup_ctr_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				echo_ident_q <= cfg_wdata;
			end
			if (take) begin
				if (req_item.cmd == CMD_SEND) begin
					sent_ctr_q <= sent_ctr_q + 1'b1;
				end else begin
					recv_ctr_q <= recv_ctr_q + 1'b1;
				end
			end
			if (state_q == ST_EVAL && dup_now) begin
				dup_ctr_q <= dup_ctr_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= req_item.cmd;
			dup_q <= 1'b0;
			if (req_item.cmd == CMD_SEND) begin
				seq_q <= sent_ctr_q + 1'b1;
				rtt_q <= '0;
			end else begin
				seq_q <= req_item.reply_seq;
				rtt_q <= rtt_new;
			end
		end
		if (state_q == ST_EVAL) begin
			dup_q <= dup_now;
		end
		if (rsp_load) begin
			rsp_q.kind       <= cmd_q;
			rsp_q.seq_out    <= seq_q;
			rsp_q.is_dup     <= dup_q;
			rsp_q.rtt_ns     <= rtt_q;
			rsp_q.sent_count <= sent_ctr_q;
			rsp_q.recv_count <= recv_ctr_q;
			rsp_q.dup_count  <= dup_ctr_q;
			rsp_q.mean_rtt   <= st_mean;
			rsp_q.min_rtt    <= st_min;
			rsp_q.max_rtt    <= st_max;
			rsp_q.var_sum    <= st_var;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	erts_rem #(
		.DEPTH (TABLE_DEPTH)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.value  ((req_item.cmd == CMD_SEND) ? sent_ctr_q + 1'b1 : req_item.reply_seq),
		.done   (rem_done),
		.slot   (rem_slot)
	);

	erts_req_table #(
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (tbl_cmd),
		.addr     (rem_slot),
		.wr_entry (tbl_wdata),
		.rd_entry (tbl_rdata),
		.clearing (tbl_clearing)
	);

	erts_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (stats_start),
		.rtt    (rtt_q),
		.cnt    (recv_ctr_q - dup_ctr_q),
		.done   (stats_done),
		.mean   (st_mean),
		.min_v  (st_min),
		.max_v  (st_max),
		.var_v  (st_var)
	);

	ap_rem_done_in_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> state_q == ST_SLOT)
		else $error("slot remainder finished outside slot state");

	ap_stats_done_in_stats: assert property (@(posedge clk) disable iff (!arst_n)
		stats_done |-> state_q == ST_STATS)
		else $error("statistics finished outside stats state");

	ap_no_stats_on_dup: assert property (@(posedge clk) disable iff (!arst_n)
		stats_start |-> cmd_q == CMD_REPLY && !dup_now && !tbl_cmd.rd)
		else $error("statistics started for send or duplicate");

	ap_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		stats_done |=> st_min <= st_max)
		else $error("min RTT above max RTT after update");

endmodule

FILE: sv/erts_rem.sv
// ----------------------------------------------------------------------------
// erts_rem
// Remainder of a sequence number by the table depth, through registers quo_s1, rem_s2 and slot_q.
// The quotient estimate from a multiply by floor(2^32 / DEPTH) is never above
// the true quotient and at most one below it, so one compare and subtract
// finishes the remainder. Only the low bits of the estimate are needed.
// ----------------------------------------------------------------------------
module erts_rem import erts_pkg::*; #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [SEQ_W-1:0]         value,
	output logic                     done,
	output logic [$clog2(DEPTH)-1:0] slot
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned RW = AW + 1;
	localparam logic [RW-1:0]    DIVISOR = RW'(DEPTH);
	localparam logic [SEQ_W-1:0] RECIP   = SEQ_W'((64'd1 << SEQ_W) / 64'(DEPTH));

	logic                   run_q;
	logic                   vld_s1;
	logic                   vld_s2;
	logic                   done_q;
	logic [SEQ_W-1:0]       val_q;
	logic [RW-1:0]          quo_s1;
	logic [RW-1:0]          rem_s2;
	logic [AW-1:0]          slot_q;
	logic [2*SEQ_W-1:0]     prod;
	logic [RW-1:0]          qd_lo;
	logic [RW-1:0]          rem_est;
	logic [RW-1:0]          rem_fix;

	assign prod    = (2*SEQ_W)'(val_q) * (2*SEQ_W)'(RECIP);
	// remainder estimate lies in 0 .. 2*DEPTH-1, so RW bits are exact
	assign qd_lo   = quo_s1 * DIVISOR;
	assign rem_est = val_q[RW-1:0] - qd_lo;
	assign rem_fix = (rem_s2 >= DIVISOR) ? rem_s2 - DIVISOR : rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= start;
			vld_s1 <= run_q;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
		end
		if (run_q) begin
			quo_s1 <= prod[SEQ_W +: RW];
		end
		if (vld_s1) begin
			rem_s2 <= rem_est;
		end
		if (vld_s2) begin
			slot_q <= rem_fix[AW-1:0];
		end
	end

	assign done = done_q;
	assign slot = slot_q;

endmodule

FILE: sv/erts_req_table.sv
// ----------------------------------------------------------------------------
// erts_req_table
// Request table memory: one port, registered read, clearing pass after reset.
// ----------------------------------------------------------------------------
module erts_req_table import erts_pkg::*; #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tbl_cmd_t                 cmd,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  tbl_entry_t               wr_entry,
	output tbl_entry_t               rd_entry,
	output logic                     clearing
);

	localparam int unsigned AW = $clog2(DEPTH);

	tbl_entry_t    mem [DEPTH];
	tbl_entry_t    rd_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	logic          we;
	logic [AW-1:0] waddr;
	tbl_entry_t    wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign we    = clr_q || cmd.wr;
	assign waddr = clr_q ? clr_addr_q : addr;
	assign wdata = clr_q ? tbl_entry_t'('0) : wr_entry;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_entry = rd_q;
	assign clearing = clr_q;

endmodule

FILE: sv/erts_stats.sv
// ----------------------------------------------------------------------------
// erts_stats
// Running RTT statistics: serial mean divider, split multiplier for the variance sum, min/max.
// ----------------------------------------------------------------------------
module erts_stats import erts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RTT_W-1:0]  rtt,
	input  logic [31:0]       cnt,
	output logic              done,
	output logic [MEAN_W-1:0] mean,
	output logic [RTT_W-1:0]  min_v,
	output logic [RTT_W-1:0]  max_v,
	output logic [VAR_W-1:0]  var_v
);

	stats_state_t         ph_q;
	stats_state_t         ph_d;
	logic [MEAN_W-1:0]    x_q;
	logic                 ge_q;
	logic [MEAN_W-1:0]    b_q;
	logic [MEAN_W-1:0]    dvd_q;
	logic [31:0]          rem_q;
	logic [31:0]          dvs_q;
	logic [DIV_CNT_W-1:0] it_q;
	logic [MEAN_W-1:0]    a_q;
	logic [MEAN_W-1:0]    pp_q;
	logic [1:0]           k_q;
	logic [PROD_W-1:0]    prod_q;
	logic [MEAN_W-1:0]    mean_q;
	logic [RTT_W-1:0]     min_q;
	logic [RTT_W-1:0]     max_q;
	logic [VAR_W-1:0]     var_q;

	logic [MEAN_W-1:0]    x_new;
	logic                 ge_new;
	logic [32:0]          rem_sh;
	logic [32:0]          rem_sub;
	logic                 qbit;
	logic [HALF_W-1:0]    a_half;
	logic [HALF_W-1:0]    b_half;
	logic [PROD_W-1:0]    pp_shift;
	logic [VAR_W:0]       var_sum;

	assign x_new  = {rtt, FRAC_BITS'(0)};
	assign ge_new = x_new >= mean_q;

	assign rem_sh  = {rem_q, dvd_q[MEAN_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign qbit    = rem_sh >= {1'b0, dvs_q};

	assign a_half = k_q[0] ? a_q[MEAN_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_half = k_q[1] ? b_q[MEAN_W-1:HALF_W] : b_q[HALF_W-1:0];

	always_comb begin
		unique case (k_q)
			2'd0:    pp_shift = PROD_W'(pp_q);
			2'd3:    pp_shift = {pp_q, MEAN_W'(0)};
			default: pp_shift = PROD_W'({pp_q, HALF_W'(0)});
		endcase
	end

	assign var_sum = {1'b0, var_q} + {1'b0, prod_q[PROD_W-1:VAR_SHIFT]};

	// next phase
	always_comb begin
		ph_d = ph_q;
		unique case (ph_q)
			SP_IDLE: if (start) ph_d = SP_DIV;
			SP_DIV:  if (it_q == DIV_CNT_W'(MEAN_W - 1)) ph_d = SP_MEAN;
			SP_MEAN: ph_d = SP_ABS;
			SP_ABS:  ph_d = SP_MUL;
			SP_MUL:  ph_d = SP_ADD;
			SP_ADD:  ph_d = (k_q == 2'd3) ? SP_VAR : SP_MUL;
			SP_VAR:  ph_d = SP_IDLE;
			default: ph_d = SP_IDLE;
		endcase
	end

	always_comb begin
		done = (ph_q == SP_VAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= SP_IDLE;
			mean_q <= '0;
			min_q  <= '1;
			max_q  <= '0;
			var_q  <= '0;
		end else begin
			ph_q <= ph_d;
			if (ph_q == SP_IDLE && start) begin
				if (rtt < min_q) min_q <= rtt;
				if (rtt > max_q) max_q <= rtt;
			end
			if (ph_q == SP_MEAN) begin
				mean_q <= ge_q ? mean_q + dvd_q : mean_q - dvd_q;
			end
			if (ph_q == SP_VAR) begin
				var_q <= var_sum[VAR_W] ? '1 : var_sum[VAR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ph_q)
			SP_IDLE: begin
				x_q   <= x_new;
				ge_q  <= ge_new;
				b_q   <= ge_new ? x_new - mean_q : mean_q - x_new;
				dvd_q <= ge_new ? x_new - mean_q : mean_q - x_new;
				rem_q <= '0;
				// zero count after wrap divides by one
				dvs_q <= (cnt == '0) ? 32'd1 : cnt;
				it_q  <= '0;
			end
			SP_DIV: begin
				rem_q <= qbit ? rem_sub[31:0] : rem_sh[31:0];
				dvd_q <= {dvd_q[MEAN_W-2:0], qbit};
				it_q  <= it_q + 1'b1;
			end
			SP_ABS: begin
				// new mean lies between old mean and x
				a_q    <= ge_q ? x_q - mean_q : mean_q - x_q;
				prod_q <= '0;
				k_q    <= '0;
			end
			SP_MUL: begin
				pp_q <= a_half * b_half;
			end
			SP_ADD: begin
				prod_q <= prod_q + pp_shift;
				k_q    <= k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign mean  = mean_q;
	assign min_v = min_q;
	assign max_v = max_q;
	assign var_v = var_q;

endmodule
